// ===== src/double_ended_list_with_search_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the double-ended list with search
// Concurrent checks on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_LIST_WITH_SEARCH_MACROS_SVH
`define DOUBLE_ENDED_LIST_WITH_SEARCH_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DELS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DELS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/dels_pkg.sv =====
// ----------------------------------------------------------------------------
// dels_pkg
// Field widths, action and status codes and shared structs of the list.
// ----------------------------------------------------------------------------
package dels_pkg;

  localparam int ACTION_W = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_SEARCH     = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0]       action;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                empty_res;
    logic [COUNT_W-1:0]  count;
    logic                found;
    logic [STATUS_W-1:0] status;
  } res_t;

endpackage

// ===== src/dels_mem.sv =====
// ----------------------------------------------------------------------------
// dels_mem
// Entry storage: one write port and one registered read port.
// ----------------------------------------------------------------------------
module dels_mem
  import dels_pkg::*;
#(
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic signed [VALUE_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic signed [VALUE_W-1:0] rd_data
);

  logic signed [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/dels_ctrl.sv =====
// ----------------------------------------------------------------------------
// dels_ctrl
// Sequencer: ring pointers, push and pop updates, and the search walk that
// reuses one equality comparator on one stored entry per cycle.
// ----------------------------------------------------------------------------
`include "double_ended_list_with_search_macros.svh"

module dels_ctrl
  import dels_pkg::*;
#(
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  req_t                      in_req,
  output logic                      wr_en,
  output logic [AW-1:0]             wr_addr,
  output logic signed [VALUE_W-1:0] wr_data,
  output logic                      rd_en,
  output logic [AW-1:0]             rd_addr,
  input  logic signed [VALUE_W-1:0] rd_data,
  output logic                      res_valid,
  input  logic                      res_ready,
  output res_t                      res
);

  localparam int SW = AW + 1;

  typedef enum logic [1:0] {
    IDLE,
    EXEC,
    SEARCH,
    DONE
  } st_t;

  st_t           state;
  req_t          req;
  logic [AW-1:0] front;
  logic [CW-1:0] held;
  logic [AW-1:0] ptr;
  logic [CW-1:0] idx;
  logic          pend;

  logic [AW-1:0] front_dec;
  logic [AW-1:0] front_inc;
  logic [AW-1:0] ptr_inc;
  logic [SW-1:0] back_sum;
  logic [AW-1:0] back_addr;
  logic [CW-1:0] held_inc;
  logic [CW-1:0] held_dec;
  logic          full;
  logic          issue;
  logic          match;

  assign front_dec = (front == '0) ? AW'(DEPTH - 1) : front - AW'(1);
  assign front_inc = (front == AW'(DEPTH - 1)) ? '0 : front + AW'(1);
  assign ptr_inc   = (ptr == AW'(DEPTH - 1)) ? '0 : ptr + AW'(1);
  // front + held stays below twice the depth, so one subtract wraps it.
  assign back_sum  = SW'(front) + SW'(held);
  assign back_addr = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);
  assign held_inc  = held + CW'(1);
  assign held_dec  = held - CW'(1);
  assign full      = (held == CW'(DEPTH));

  assign issue = (state == SEARCH) && (idx != held);
  assign match = pend && (rd_data == req.value);

  assign in_ready  = (state == IDLE);
  assign res_valid = (state == DONE);
  assign rd_en     = issue;
  assign rd_addr   = ptr;
  assign wr_data   = req.value;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = back_addr;
    if (state == EXEC && !full) begin
      if (req.action == ACT_PUSH_FRONT) begin
        wr_en   = 1'b1;
        wr_addr = front_dec;
      end else if (req.action == ACT_PUSH_BACK) begin
        wr_en   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      front <= '0;
      held  <= '0;
      pend  <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid) begin
            req   <= in_req;
            state <= EXEC;
          end
        end
        EXEC: begin
          res.status    <= STATUS_OK;
          res.found     <= 1'b0;
          res.count     <= COUNT_W'(held);
          res.empty_res <= (held == '0);
          state         <= DONE;
          case (req.action)
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
              if (full) begin
                res.status <= STATUS_FULL;
              end else begin
                held          <= held_inc;
                res.count     <= COUNT_W'(held_inc);
                res.empty_res <= 1'b0;
                if (req.action == ACT_PUSH_FRONT) begin
                  front <= front_dec;
                end
              end
            end
            ACT_POP_FRONT, ACT_POP_BACK: begin
              if (held == '0) begin
                res.status <= STATUS_EMPTY;
              end else begin
                held          <= held_dec;
                res.count     <= COUNT_W'(held_dec);
                res.empty_res <= (held_dec == '0);
                if (req.action == ACT_POP_FRONT) begin
                  front <= front_inc;
                end
              end
            end
            ACT_SEARCH: begin
              ptr   <= front;
              idx   <= '0;
              pend  <= 1'b0;
              state <= SEARCH;
            end
            default: begin
            end
          endcase
        end
        SEARCH: begin
          // Each cycle reads the next entry and compares the one read before.
          if (match || !issue) begin
            res.found <= match;
            pend      <= 1'b0;
            state     <= DONE;
          end else begin
            ptr  <= ptr_inc;
            idx  <= idx + CW'(1);
            pend <= 1'b1;
          end
        end
        DONE: begin
          if (res_ready) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  `DELS_ASSERT_SAME(a_held_bound, 1'b1, held <= CW'(DEPTH), "held count beyond depth")
  `DELS_ASSERT_SAME(a_idx_bound, state == SEARCH, idx <= held, "search index past held")
  `DELS_ASSERT_SAME(a_full_status, res_valid && res.status == STATUS_FULL, full,
                    "full status while list not full")
  `DELS_ASSERT_SAME(a_empty_status, res_valid && res.status == STATUS_EMPTY, held == '0,
                    "empty status while list holds entries")
  `DELS_ASSERT_NEXT(a_search_done, state == SEARCH && !issue, state == DONE,
                    "search did not end after last entry")

endmodule

// ===== src/double_ended_list_with_search.sv =====
// ----------------------------------------------------------------------------
// double_ended_list_with_search
// A bounded double-ended list of DEPTH signed 32-bit values held in a ring
// buffer. Each input transaction carries an action in s_axis_tuser (push
// front, push back, pop front, pop back, search) and a value in s_axis_tdata,
// and yields one result transaction with a status, a found flag, the count of
// held entries after the action (masked to 5 bits) and an empty flag. The
// block takes one transaction at a time: a push or a pop passes through the
// execute and done states before its result is loaded into the output
// register, and a search walks the storage memory's single read port, one
// entry per cycle, ending at the first match. The input is ready again in
// the cycle after that load.
// The output register lets a new transaction be accepted while a result waits.
// ----------------------------------------------------------------------------
module double_ended_list_with_search
  import dels_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Input channel.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic [2:0]  s_axis_tuser,   // [2:0] action
  // Result channel.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [1:0] status, [2] found, [7:3] count,
                                      // [8] empty_res, [15:9] zero
);

  localparam int AW = $clog2(DEPTH);

  req_t                      in_req;
  res_t                      res;
  logic                      res_valid;
  logic                      res_ready;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic signed [VALUE_W-1:0] wr_data;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic signed [VALUE_W-1:0] rd_data;

  assign in_req.action = s_axis_tuser;
  assign in_req.value  = s_axis_tdata;

  // The output register is free when empty or when its result leaves now.
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  dels_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_req    (in_req),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  dels_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Result register: loads when the sequencer hands over a finished result.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_axis_tdata <= {7'd0, res};
    end
  end

endmodule

// ===== tb/sv/list_action_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// list_action_checker
// Watches both stream channels of the double-ended list. It predicts the
// outcome of every accepted input transaction and compares each accepted
// result transaction against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module list_action_checker
  import dels_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic [2:0]  s_axis_tuser,   // [2:0] action
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // [1:0] status, [2] found, [7:3] count,
                                      // [8] empty_res, [15:9] zero
  output int          mismatches,
  output int          outstanding
);

  // Shadow copy of the list contents.
  logic [VALUE_W-1:0] slots [DEPTH];
  int unsigned        front_slot;
  int unsigned        held;

  res_t pending_outcomes [$];
  res_t want;
  res_t got;

  function automatic res_t apply_action(input logic [ACTION_W-1:0] act,
                                        input logic [VALUE_W-1:0]  val);
    res_t        r;
    int unsigned k;
    r = '0;
    r.status = STATUS_OK;
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (held == DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          if (act == ACT_PUSH_FRONT) begin
            front_slot = (front_slot + DEPTH - 1) % DEPTH;
            slots[front_slot] = val;
          end else begin
            slots[(front_slot + held) % DEPTH] = val;
          end
          held++;
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        if (held == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          if (act == ACT_POP_FRONT) begin
            front_slot = (front_slot + 1) % DEPTH;
          end
          held--;
        end
      end
      ACT_SEARCH: begin
        for (k = 0; k < held; k++) begin
          if (slots[(front_slot + k) % DEPTH] == val) begin
            r.found = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    r.count     = COUNT_W'(held);
    r.empty_res = (held == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      front_slot = 0;
      held       = 0;
      mismatches = 0;
      pending_outcomes.delete();
    end else begin
      // A result can never belong to an item accepted in the same cycle, so
      // the output side is handled first.
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_outcomes.size() == 0) begin
          $error("result transaction with no outstanding prediction: %h", m_axis_tdata);
          mismatches++;
        end else begin
          want = pending_outcomes.pop_front();
          got  = res_t'(m_axis_tdata[$bits(res_t)-1:0]);
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
          end
          if (got.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, got.found);
            mismatches++;
          end
          if (got.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, got.count);
            mismatches++;
          end
          if (got.empty_res !== want.empty_res) begin
            $error("empty_res: expected %0d, got %0d", want.empty_res, got.empty_res);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pending_outcomes.push_back(apply_action(s_axis_tuser, s_axis_tdata));
      end
    end
    outstanding = pending_outcomes.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the double-ended list with search. A short
// directed sequence covers the empty and full corners, the extreme values and
// the spare action codes; random phases follow with varying push/pop balance,
// searches biased toward values recently pushed, and random idling on both
// channels. A checker module beside the block does the prediction.
// ----------------------------------------------------------------------------
module tb;
  import dels_pkg::*;

  localparam int DEPTH        = 16;
  localparam int RANDOM_ITEMS = 1000;
  localparam int PHASES       = 10;
  // Long receiver hold-off, long enough for the block to back up completely.
  localparam int HOLD_CYCLES  = 300;
  // Cycles with no transaction on either channel before the run is declared
  // hung. The slowest legitimate quiet stretch is the hold-off above.
  localparam int STALL_LIMIT  = 3000;
  // Wait well past the time that a full-list search takes.
  localparam int TAIL_CYCLES  = 4 * DEPTH;

  // Action codes the block must accept and ignore.
  localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

  localparam logic [VALUE_W-1:0] VAL_MIN  = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] VAL_MAX  = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] VAL_ONES = 32'hFFFF_FFFF;

  logic        clk;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;   // [31:0] value
  logic [2:0]  s_axis_tuser  = '0;   // [2:0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [1:0] status, [2] found, [7:3] count,
                                     // [8] empty_res, [15:9] zero

  int mismatches;
  int outstanding;

  // Percent chance that a transaction is preceded by an idle burst, per side.
  int tx_gap_odds = 0;
  int rx_gap_odds = 0;
  // Set by the stimulus to ask the receiver for one long hold-off; the
  // receiver clears it when the hold-off is over.
  bit hold_req    = 1'b0;
  int quiet_cycles = 0;

  // Small pool of values pushed lately, so that searches often hit.
  logic [VALUE_W-1:0] recent_values [8];

  double_ended_list_with_search #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  list_action_checker #(
    .DEPTH(DEPTH)
  ) i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: any transaction on either channel counts as progress.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Receiver. All changes happen at the falling edge. The long hold-off is
  // counted here, independent of what the sender is doing, so the sender can
  // keep offering transactions while the block backs up.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (rx_gap_odds != 0 && $urandom_range(1, 100) <= rx_gap_odds) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offers one input transaction. Called at a falling edge and returns at the
  // falling edge after acceptance with tvalid still high, so that the next
  // call can either present new data right away or open an idle gap without
  // ever lowering and raising tvalid in the same time step.
  task automatic offer(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] val);
    int gap;
    gap = 0;
    if (tx_gap_odds != 0 && $urandom_range(1, 100) <= tx_gap_odds) begin
      gap = $urandom_range(1, 11);
    end
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= val;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    // Remember pushed values so later searches can find them.
    if (act == ACT_PUSH_FRONT || act == ACT_PUSH_BACK) begin
      recent_values[$urandom_range(0, 7)] = val;
    end
  endtask

  // Stops offering until every outstanding result has come back. The extra
  // falling edge keeps the lowering of tvalid apart from the next raise.
  task automatic pause_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  // Mostly pushes, pops and searches in a per-phase balance, with a few
  // spare action codes mixed in.
  function automatic logic [ACTION_W-1:0] pick_action(input int push_pct,
                                                      input int search_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      return ACTION_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
    end
    if (r < 3 + search_pct) begin
      return ACT_SEARCH;
    end
    if ($urandom_range(0, 99) < push_pct) begin
      return $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
    end
    return $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
  endfunction

  // Values come from the recent pool, a narrow band around zero (to force
  // duplicates), the extremes, or anywhere in the 32-bit range.
  function automatic logic [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      return recent_values[$urandom_range(0, 7)];
    end
    if (r < 50) begin
      return VALUE_W'(int'($urandom_range(0, 16)) - 8);
    end
    if (r < 60) begin
      case ($urandom_range(0, 3))
        0:       return VAL_MIN;
        1:       return VAL_MAX;
        2:       return '0;
        default: return VAL_ONES;
      endcase
    end
    return $urandom();
  endfunction

  initial begin : stimulus
    int                 k;
    int                 phase;
    int                 push_pct;
    int                 search_pct;
    logic [ACTION_W-1:0] act;

    for (k = 0; k < 8; k++) begin
      recent_values[k] = '0;
    end

    // Reset is held from time zero and released once, at a falling edge.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ---------------- Directed part ----------------
    tx_gap_odds = 20;
    rx_gap_odds = 20;

    // Empty list: both pops must report empty, a search must miss.
    offer(ACT_POP_FRONT, $urandom());
    offer(ACT_POP_BACK, $urandom());
    offer(ACT_SEARCH, '0);
    // Spare action codes change nothing and report ok.
    for (k = ACT_SPARE_LO; k <= ACT_SPARE_HI; k++) begin
      offer(ACTION_W'(k), $urandom());
    end

    // Extremes at both ends, then fill the list to capacity from both sides.
    offer(ACT_PUSH_FRONT, VAL_MIN);
    offer(ACT_PUSH_BACK, VAL_MAX);
    for (k = 0; k < DEPTH - 2; k++) begin
      offer((k % 2) ? ACT_PUSH_FRONT : ACT_PUSH_BACK, VALUE_W'(32'h100 + k));
    end

    // Full list: both pushes are refused.
    offer(ACT_PUSH_FRONT, '0);
    offer(ACT_PUSH_BACK, VAL_ONES);

    // Search hits and a miss that walks every entry.
    offer(ACT_SEARCH, VAL_MAX);
    offer(ACT_SEARCH, VAL_MIN);
    offer(ACT_SEARCH, 32'h0000_0001);

    // Remove the outermost entries; the extremes sit further in, so a search
    // for the maximum must still hit.
    offer(ACT_POP_FRONT, $urandom());
    offer(ACT_POP_BACK, $urandom());
    offer(ACT_SEARCH, VAL_MAX);

    pause_until_drained();

    // ---------------- Random part ----------------
    for (phase = 0; phase < PHASES; phase++) begin
      // Rotate between filling, draining and balanced traffic so the list
      // keeps hitting both its empty and its full state.
      case (phase % 3)
        0:       push_pct = 80;
        1:       push_pct = 20;
        default: push_pct = 50;
      endcase
      search_pct = $urandom_range(10, 40);

      if (phase == PHASES - 1 || phase % 3 == 2) begin
        // No idling at all: the final phase and a few stretches earlier on.
        tx_gap_odds = 0;
        rx_gap_odds = 0;
      end else begin
        tx_gap_odds = $urandom_range(5, 40);
        rx_gap_odds = $urandom_range(5, 40);
      end

      if (phase == 4) begin
        // Back-pressure: the receiver holds off while the sender keeps
        // offering back to back until the block stalls its input.
        tx_gap_odds = 0;
        hold_req    = 1'b1;
      end

      for (k = 0; k < RANDOM_ITEMS / PHASES; k++) begin
        act = pick_action(push_pct, search_pct);
        offer(act, pick_value());
      end

      if (phase == 6) begin
        pause_until_drained();
      end
    end

    // ---------------- Wind-down ----------------
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    // Let any stray result show up before the verdict.
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
